[rtl/core/art_pkg.sv]
// Shared types and constants for the allocation reference tracker.
package art_pkg;

  // Fixed field widths
  localparam int ADDR_W  = 48;
  localparam int LEN_W   = 32;
  localparam int THR_W   = 4;
  localparam int REFS_W  = 4;
  localparam int TOTAL_W = 7;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 3;

  localparam logic [THR_W-1:0] THR_RESET = 4'd1;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_RECORD     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SCAN_BEGIN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SCAN_WORD  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REPORT     = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_DONE     = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_OVERLAP  = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_NO_MATCH = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_STOPPED  = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               entry_present;
    logic [ADDR_W-1:0]  entry_base;
    logic [LEN_W-1:0]   entry_length;
    logic               leak_flag;
    logic [TOTAL_W-1:0] leak_total;
    logic               last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REPORT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;         // capture the incoming request
    logic exec;         // apply the held request
    logic report_step;  // emit the next report entry
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result;    // executing the held request yields one result
    logic report_begin;  // report request with at least one live entry
    logic report_last;   // current report entry is the final one
  } stat_t;

endpackage

[rtl/core/art_datapath.sv]
// Range table, lane compares, scan counters and result register of the tracker.
module art_datapath #(
  parameter int CAPACITY     = 16,
  parameter int ADDRESS_BITS = 48
) (
  input  logic                       clk,
  input  logic                       rst,
  input  art_pkg::cmd_t              cmd,
  output art_pkg::stat_t             stat,
  input  art_pkg::in_t               in_data,
  input  logic                       cfg_wr_en,
  input  logic [art_pkg::THR_W-1:0]  cfg_wr_data,
  output art_pkg::out_t              out_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = (ADDRESS_BITS > art_pkg::LEN_W) ? ADDRESS_BITS : art_pkg::LEN_W;

  art_pkg::in_t                   req;
  logic [ADDRESS_BITS-1:0]        req_addr;
  logic [CAPACITY-1:0]            live;
  logic                           stopped;
  logic [art_pkg::THR_W-1:0]      thr;
  logic [ADDRESS_BITS-1:0]        slot_base   [CAPACITY];
  logic [art_pkg::LEN_W-1:0]      slot_length [CAPACITY];
  logic [art_pkg::REFS_W-1:0]     slot_refs   [CAPACITY];
  logic [CAPACITY-1:0]            contain;
  logic [CAPACITY-1:0]            overlap;
  logic [CAPACITY-1:0]            below;
  logic [IW-1:0]                  free_idx;
  logic [IW-1:0]                  hit_idx;
  logic [IW-1:0]                  rep_idx;
  logic [CAPACITY-1:0]            rep_mask;
  logic [CAPACITY-1:0]            rep_rest;
  logic [art_pkg::TOTAL_W-1:0]    rep_total;
  logic [art_pkg::TOTAL_W-1:0]    rep_total_next;
  logic [art_pkg::STAT_W-1:0]     exec_status;
  logic                           rec_ok;
  art_pkg::out_t                  exec_out;
  art_pkg::out_t                  step_out;

  assign req_addr = ADDRESS_BITS'(req.address);

  // Per-lane range compares against the held request
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      contain[i] = live[i] && (slot_base[i] <= req_addr) &&
                   (CW'(req_addr - slot_base[i]) < CW'(slot_length[i]));
      overlap[i] = live[i] &&
                   !(((req_addr <= slot_base[i]) &&
                      (CW'(slot_base[i] - req_addr) >= CW'(req.length))) ||
                     ((slot_base[i] <= req_addr) &&
                      (CW'(req_addr - slot_base[i]) >= CW'(slot_length[i]))));
      below[i]   = slot_refs[i] < thr;
    end
  end

  // Lowest-index pick for free slot, containing slot and next report entry
  always_comb begin
    free_idx = '0;
    hit_idx  = '0;
    rep_idx  = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!live[i])    free_idx = IW'(i);
      if (contain[i])  hit_idx  = IW'(i);
      if (rep_mask[i]) rep_idx  = IW'(i);
    end
  end

  // Report mask with its lowest set bit dropped
  assign rep_rest       = rep_mask & (rep_mask - CAPACITY'(1));
  assign rep_total_next = rep_total + art_pkg::TOTAL_W'(below[rep_idx]);

  // Status of the held request
  always_comb begin
    exec_status = art_pkg::STATUS_DONE;
    rec_ok      = 1'b0;
    unique case (req.mode)
      art_pkg::MODE_RECORD: begin
        if (&live)         exec_status = art_pkg::STATUS_FULL;
        else if (|overlap) exec_status = art_pkg::STATUS_OVERLAP;
        else               rec_ok      = 1'b1;
      end
      art_pkg::MODE_RELEASE: begin
        if (!(|contain)) exec_status = art_pkg::STATUS_NO_MATCH;
      end
      art_pkg::MODE_SCAN_WORD: begin
        if (stopped)           exec_status = art_pkg::STATUS_STOPPED;
        else if (!(|contain))  exec_status = art_pkg::STATUS_NO_MATCH;
      end
      default: ;
    endcase
  end

  assign stat.has_result   = (req.mode <= art_pkg::MODE_SCAN_WORD) ||
                             ((req.mode == art_pkg::MODE_REPORT) && (live == '0));
  assign stat.report_begin = (req.mode == art_pkg::MODE_REPORT) && (live != '0);
  assign stat.report_last  = (rep_rest == '0);

  // Single result of a non-report request, or of an empty report
  always_comb begin
    exec_out        = '0;
    exec_out.status = exec_status;
    exec_out.last   = 1'b1;
  end

  // One report entry
  always_comb begin
    step_out               = '0;
    step_out.status        = art_pkg::STATUS_DONE;
    step_out.entry_present = 1'b1;
    step_out.entry_base    = art_pkg::ADDR_W'(slot_base[rep_idx]);
    step_out.entry_length  = slot_length[rep_idx];
    step_out.leak_flag     = below[rep_idx];
    step_out.leak_total    = (rep_rest == '0) ? rep_total_next : '0;
    step_out.last          = (rep_rest == '0);
  end

  // Control state: live bits, stop flag, threshold, report walk
  always_ff @(posedge clk) begin
    if (rst) begin
      live      <= '0;
      stopped   <= 1'b0;
      thr       <= art_pkg::THR_RESET;
      rep_mask  <= '0;
      rep_total <= '0;
    end else begin
      if (cfg_wr_en) thr <= cfg_wr_data;
      if (cmd.exec) begin
        unique case (req.mode)
          art_pkg::MODE_RECORD: begin
            if (rec_ok) live[free_idx] <= 1'b1;
            else        stopped        <= 1'b1;
          end
          art_pkg::MODE_RELEASE: begin
            if (|contain) live[hit_idx] <= 1'b0;
          end
          art_pkg::MODE_REPORT: begin
            rep_mask  <= live;
            rep_total <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.report_step) begin
        rep_mask  <= rep_rest;
        rep_total <= rep_total_next;
      end
    end
  end

  // Payload: held request, slot contents, result register
  always_ff @(posedge clk) begin
    if (cmd.load) req <= in_data;
    if (cmd.exec) begin
      unique case (req.mode)
        art_pkg::MODE_RECORD: begin
          if (rec_ok) begin
            slot_base[free_idx]   <= req_addr;
            slot_length[free_idx] <= req.length;
            slot_refs[free_idx]   <= '0;
          end
        end
        art_pkg::MODE_SCAN_BEGIN: begin
          for (int i = 0; i < CAPACITY; i++) slot_refs[i] <= '0;
        end
        art_pkg::MODE_SCAN_WORD: begin
          // saturate at the threshold
          if (!stopped && (|contain) && below[hit_idx])
            slot_refs[hit_idx] <= slot_refs[hit_idx] + art_pkg::REFS_W'(1);
        end
        default: ;
      endcase
      if (stat.has_result) out_data <= exec_out;
    end
    if (cmd.report_step) out_data <= step_out;
  end

  // Stop flag is sticky until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("stop flag cleared without reset");

  // Report walk only steps over a non-empty mask
  a_step_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.report_step |-> (rep_mask != '0))
    else $error("report step with no entry left");

  // At most one slot becomes live per cycle
  a_one_alloc: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(live) <= $countones($past(live)) + 1))
    else $error("more than one slot allocated at once");

endmodule

[rtl/core/art_ctrl.sv]
// Request sequencing state machine and result valid register of the tracker.
module art_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  art_pkg::stat_t stat,
  output art_pkg::cmd_t  cmd
);

  art_pkg::state_t state;
  art_pkg::state_t state_next;
  logic            out_free;
  logic            emit;
  logic            out_valid_next;

  // Result register can take a new result this cycle
  assign out_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      art_pkg::ST_IDLE: begin
        if (in_valid) state_next = art_pkg::ST_EXEC;
      end
      art_pkg::ST_EXEC: begin
        if (out_free)
          state_next = stat.report_begin ? art_pkg::ST_REPORT : art_pkg::ST_IDLE;
      end
      art_pkg::ST_REPORT: begin
        if (out_free && stat.report_last) state_next = art_pkg::ST_IDLE;
      end
      default: state_next = art_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      art_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      art_pkg::ST_EXEC:   cmd.exec        = out_free;
      art_pkg::ST_REPORT: cmd.report_step = out_free;
      default: ;
    endcase
  end

  assign emit           = (cmd.exec && stat.has_result) || cmd.report_step;
  assign out_valid_next = (out_valid && out_stall) || emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= art_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !emit)
    else $error("result register overwritten while stalled");

  // Requests are taken only when no request is in progress
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == art_pkg::ST_EXEC))
    else $error("accepted request did not enter execution");

  // Report walk is entered only from execution
  a_report_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == art_pkg::ST_REPORT) |-> ($past(state) == art_pkg::ST_EXEC))
    else $error("report walk entered from wrong state");

endmodule

[rtl/core/allocation_reference_tracker_top.sv]
// Top level of the allocation reference tracker: controller plus range datapath.
// A request is taken in the idle state and applied in the execute state; record,
// release, begin-scan and scanned-word requests give one result each. Every live
// slot is compared in parallel in the execute cycle, and the matching count is
// updated there. A report request spends its execute cycle latching the live
// mask, then emits one result per live slot, one per cycle while the output is
// not stalled, lowest slot first (a report with no live slot gives a single
// result in its execute cycle). Execution and report output hold while an
// earlier result waits in the output register under stall. No request is
// accepted until the previous one has produced all its results.
module allocation_reference_tracker_top #(
  parameter int CAPACITY     = 16,
  parameter int ADDRESS_BITS = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  art_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output art_pkg::out_t             out_data,
  input  logic                      cfg_wr_en,
  input  logic [art_pkg::THR_W-1:0] cfg_wr_data
);

  art_pkg::cmd_t  cmd;
  art_pkg::stat_t stat;

  art_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  art_datapath #(
    .CAPACITY     (CAPACITY),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

endmodule

[verif/allocation_reference_tracker_top_test.sv]
// Self-checking testbench for the allocation reference tracker: directed and random requests.
`timescale 1ns / 1ps

module allocation_reference_tracker_top_test;
  import art_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int SLOTS = 16;
  localparam int ZONES = 16;
  localparam int ZONE_SHIFT = 44;
  localparam logic [63:0] ZONE_SPAN = 64'd1 << ZONE_SHIFT;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [MODE_W-1:0] MODE_FIRST_UNUSED = MODE_REPORT + 1'b1;
  localparam logic [MODE_W-1:0] MODE_LAST_UNUSED = {MODE_W{1'b1}};

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_wr_en;
  logic [THR_W-1:0] cfg_wr_data;

  allocation_reference_tracker_top #(
    .CAPACITY(SLOTS),
    .ADDRESS_BITS(ADDR_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Requests waiting to be driven, and results the tracker model predicts
  in_t req_queue[$];
  out_t predicted_results[$];
  int pushed_count = 0;
  int issued_count = 0;
  int accepted_count = 0;
  int fail_count = 0;
  bit calm_tail = 1'b0;

  // Tracker model state
  bit tbl_live[SLOTS];
  logic [ADDR_W-1:0] tbl_base[SLOTS];
  logic [LEN_W-1:0] tbl_len[SLOTS];
  logic [REFS_W-1:0] tbl_refs[SLOTS];
  bit tbl_stopped = 1'b0;
  logic [THR_W-1:0] tbl_threshold = THR_RESET;

  // Stimulus-side view of which address zones hold a live range
  bit zone_busy[ZONES];
  logic [63:0] zone_base[ZONES];
  logic [63:0] zone_len[ZONES];
  int slots_in_use = 0;
  int zero_len_count = 0;
  int scan_target = -1;

  function automatic bit spans_overlap(logic [63:0] a, logic [63:0] la,
                                       logic [63:0] b, logic [63:0] lb);
    if (a <= b && b - a >= la) return 1'b0;
    if (b <= a && a - b >= lb) return 1'b0;
    return 1'b1;
  endfunction

  // Lowest live slot whose range holds the address, -1 if none
  function automatic int containing_slot(logic [63:0] p);
    logic [63:0] base;
    logic [63:0] len;
    for (int i = 0; i < SLOTS; i++) begin
      base = tbl_base[i];
      len = tbl_len[i];
      if (tbl_live[i] && base <= p && p - base < len) return i;
    end
    return -1;
  endfunction

  // Apply one accepted request to the model and queue the results it causes
  task automatic predict_request(input in_t r);
    out_t res;
    int free_slot;
    int hit;
    int n_live;
    bit single;
    logic [TOTAL_W-1:0] leaks;
    res = '0;
    res.status = STATUS_DONE;
    res.last = 1'b1;
    single = 1'b1;
    case (r.mode)
      MODE_RECORD: begin
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!tbl_live[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          res.status = STATUS_FULL;
          tbl_stopped = 1'b1;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_live[i] && spans_overlap(r.address, r.length, tbl_base[i], tbl_len[i]))
              res.status = STATUS_OVERLAP;
          end
          if (res.status == STATUS_OVERLAP) begin
            tbl_stopped = 1'b1;
          end else begin
            tbl_live[free_slot] = 1'b1;
            tbl_base[free_slot] = r.address;
            tbl_len[free_slot] = r.length;
            tbl_refs[free_slot] = '0;
          end
        end
      end
      MODE_RELEASE: begin
        hit = containing_slot(r.address);
        if (hit < 0) res.status = STATUS_NO_MATCH;
        else tbl_live[hit] = 1'b0;
      end
      MODE_SCAN_BEGIN: begin
        for (int i = 0; i < SLOTS; i++) tbl_refs[i] = '0;
      end
      MODE_SCAN_WORD: begin
        if (tbl_stopped) begin
          res.status = STATUS_STOPPED;
        end else begin
          hit = containing_slot(r.address);
          if (hit < 0) res.status = STATUS_NO_MATCH;
          else if (tbl_refs[hit] < tbl_threshold) tbl_refs[hit] = tbl_refs[hit] + 1'b1;
        end
      end
      MODE_REPORT: begin
        single = 1'b0;
        n_live = 0;
        leaks = '0;
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_live[i]) begin
            res = '0;
            res.status = STATUS_DONE;
            res.entry_present = 1'b1;
            res.entry_base = tbl_base[i];
            res.entry_length = tbl_len[i];
            res.leak_flag = tbl_refs[i] < tbl_threshold;
            leaks += res.leak_flag;
            predicted_results.push_back(res);
            n_live++;
          end
        end
        if (n_live == 0) begin
          res = '0;
          res.last = 1'b1;
          predicted_results.push_back(res);
        end else begin
          res = predicted_results.pop_back();
          res.leak_total = leaks;
          res.last = 1'b1;
          predicted_results.push_back(res);
        end
      end
      default: single = 1'b0;  // undefined modes are dropped
    endcase
    if (single) predicted_results.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Result checking and request tracking, sampled at the rising edge
  always @(posedge clk) begin
    out_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("entry_present", want.entry_present, out_data.entry_present);
          check_field("entry_base", want.entry_base, out_data.entry_base);
          check_field("entry_length", want.entry_length, out_data.entry_length);
          check_field("leak_flag", want.leak_flag, out_data.leak_flag);
          check_field("leak_total", want.leak_total, out_data.leak_total);
          check_field("last", want.last, out_data.last);
        end
      end
      if (in_valid && !in_stall) begin
        predict_request(in_data);
        accepted_count++;
      end
    end
  end

  // Request driver: random gaps, holds the payload until it is taken
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst && !(in_valid && accepted_count != issued_count)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (req_queue.size() != 0 && !calm_tail && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        gap_left = $urandom_range(1, 14) - 1;
      end else if (req_queue.size() != 0) begin
        in_data <= req_queue.pop_front();
        in_valid <= 1'b1;
        issued_count++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: random bursts plus one long hold-off so the tracker backs up
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && accepted_count >= 40) begin
      hold_done = 1'b1;
      hold_left = 119;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(1, 14) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void queue_request(logic [MODE_W-1:0] mode, logic [63:0] addr,
                                        logic [63:0] len);
    in_t r;
    r.mode = mode;
    r.address = addr[ADDR_W-1:0];
    r.length = len[LEN_W-1:0];
    req_queue.push_back(r);
    pushed_count++;
  endfunction

  function automatic logic [63:0] zone_origin(int k);
    return 64'(k) << ZONE_SHIFT;
  endfunction

  function automatic int pick_zone(bit busy);
    int cands[$];
    for (int k = 0; k < ZONES; k++) begin
      if (zone_busy[k] == busy) cands.push_back(k);
    end
    if (cands.size() == 0) return -1;
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  // Address inside the zone's live range, edges included
  function automatic logic [63:0] point_in(int k);
    case ($urandom_range(0, 3))
      0: return zone_base[k];
      1: return zone_base[k] + zone_len[k] - 1;
      default: return zone_base[k] + ($urandom % zone_len[k]);
    endcase
  endfunction

  // Address in a zone with no live range; only empty ranges may sit there
  function automatic logic [63:0] point_outside(int k);
    return zone_origin(k) + ({$urandom, $urandom} % ZONE_SPAN);
  endfunction

  // Random well-formed traffic: ranges never overlap and the table never fills
  task automatic queue_random(input int count);
    int n;
    int pick;
    int k;
    int j;
    logic [63:0] len;
    logic [63:0] base;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      k = pick_zone(1'b1);
      j = pick_zone(1'b0);
      if (pick < 22) begin
        if (slots_in_use < SLOTS && zero_len_count < 3 && $urandom_range(0, 31) == 0) begin
          // empty range on a zone boundary never overlaps anything
          queue_request(MODE_RECORD, zone_origin($urandom_range(0, ZONES - 1)), 0);
          slots_in_use++;
          zero_len_count++;
          n++;
        end else if (slots_in_use < SLOTS && j >= 0) begin
          case ($urandom_range(0, 2))
            0: len = 64'($urandom_range(1, 64));
            1: len = 64'($urandom_range(1, 65535));
            default: len = 64'($urandom);
          endcase
          if (len == 0) len = 1;
          base = zone_origin(j) + ({$urandom, $urandom} % (ZONE_SPAN - len));
          zone_busy[j] = 1'b1;
          zone_base[j] = base;
          zone_len[j] = len;
          slots_in_use++;
          queue_request(MODE_RECORD, base, len);
          n++;
        end
      end else if (pick < 37) begin
        if (k >= 0 && (j < 0 || $urandom_range(0, 4) != 0)) begin
          queue_request(MODE_RELEASE, point_in(k), $urandom);
          zone_busy[k] = 1'b0;
          slots_in_use--;
        end else begin
          queue_request(MODE_RELEASE, point_outside(j), $urandom);
        end
        n++;
      end else if (pick < 42) begin
        queue_request(MODE_SCAN_BEGIN, {$urandom, $urandom}, $urandom);
        n++;
      end else if (pick < 88) begin
        // keep hitting the same range often so counts reach the threshold
        if (scan_target >= 0 && zone_busy[scan_target] && $urandom_range(0, 1) == 1)
          k = scan_target;
        if (k >= 0 && (j < 0 || $urandom_range(0, 3) != 0)) begin
          scan_target = k;
          queue_request(MODE_SCAN_WORD, point_in(k), $urandom);
        end else begin
          queue_request(MODE_SCAN_WORD, point_outside(j), $urandom);
        end
        n++;
      end else if (pick < 96) begin
        queue_request(MODE_REPORT, {$urandom, $urandom}, $urandom);
        n++;
      end else begin
        queue_request(MODE_W'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED)),
                      {$urandom, $urandom}, $urandom);
      end
    end
  endtask

  task automatic release_busy_zones();
    for (int k = 0; k < ZONES; k++) begin
      if (zone_busy[k]) begin
        queue_request(MODE_RELEASE, point_in(k), 0);
        zone_busy[k] = 1'b0;
        slots_in_use--;
      end
    end
  endtask

  // Wait until every request is taken and every result is back
  task automatic wait_idle();
    @(negedge clk);
    while (!(accepted_count == pushed_count && predicted_results.size() == 0))
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    wait_idle();
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tbl_threshold = value;
  endtask

  initial begin
    logic [63:0] z5;
    int fill;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    for (int i = 0; i < SLOTS; i++) tbl_live[i] = 1'b0;
    for (int k = 0; k < ZONES; k++) zone_busy[k] = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, every mode, containment edges, threshold at reset value
    @(posedge clk);
    queue_request(MODE_REPORT, 0, 0);                     // empty table
    queue_request(MODE_RECORD, 0, 32'hFFFF_FFFF);         // lowest base, longest range
    queue_request(MODE_RECORD, 48'hFFFF_FFFF_FFFF, 1);    // highest base
    queue_request(MODE_RECORD, zone_origin(8), 0);        // empty range, stays live
    queue_request(MODE_SCAN_WORD, 48'hFFFF_FFFF_FFFF, 0);
    queue_request(MODE_SCAN_WORD, 48'hFFFF_FFFF_FFFF, 0); // already at threshold
    queue_request(MODE_SCAN_WORD, zone_origin(8), 0);     // empty range holds nothing
    queue_request(MODE_SCAN_WORD, 32'hFFFF_FFFE, 0);      // last byte of a range
    queue_request(MODE_SCAN_WORD, 32'hFFFF_FFFF, 0);      // one past the end
    queue_request(MODE_REPORT, 0, 0);
    queue_request(MODE_SCAN_BEGIN, 0, 0);
    queue_request(MODE_REPORT, 0, 0);
    queue_request(MODE_RELEASE, 48'h1234, 0);
    queue_request(MODE_RELEASE, 48'h1234, 0);             // miss after release
    queue_request(MODE_RELEASE, zone_origin(8), 0);       // empty range cannot match
    queue_request(MODE_RECORD, 48'h1000, 16);             // reuses lowest free slot
    for (int m = MODE_FIRST_UNUSED; m <= MODE_LAST_UNUSED; m++)
      queue_request(MODE_W'(m), {$urandom, $urandom}, $urandom);
    queue_request(MODE_RELEASE, 48'h1000, 0);
    queue_request(MODE_RELEASE, 48'hFFFF_FFFF_FFFF, 0);
    queue_request(MODE_REPORT, 0, 0);
    slots_in_use = 1;
    zero_len_count = 1;

    // Random traffic across threshold settings; the long hold-off lands here
    queue_random(30);
    write_threshold('0);
    @(posedge clk);
    queue_random(20);
    write_threshold('1);
    @(posedge clk);
    queue_random(25);
    write_threshold(THR_W'($urandom_range(2, 14)));
    @(posedge clk);
    queue_random(15);
    wait_idle();

    // Rejections latch the stop flag until reset, so they come last
    @(posedge clk);
    calm_tail = 1'b1;
    release_busy_zones();
    z5 = zone_origin(5);
    queue_request(MODE_RECORD, z5 + 'h1000, 'h1000);
    queue_request(MODE_RECORD, z5 + 'h1800, 'h100);       // overlap
    queue_request(MODE_RECORD, z5 + 'h1800, 0);           // empty range strictly inside
    queue_request(MODE_RECORD, z5 + 'h2000, 'h10);        // starts at the end: fine
    queue_request(MODE_RECORD, z5 + 'h0800, 'h800);       // ends at the start: fine
    queue_request(MODE_SCAN_WORD, z5 + 'h1000, 0);        // ignored while stopped
    queue_request(MODE_SCAN_WORD, 0, 32'hFFFF_FFFF);
    fill = SLOTS - slots_in_use - 3;
    for (int i = 0; i < fill; i++)
      queue_request(MODE_RECORD, zone_origin(7) + i * 'h10000, 'h100);
    queue_request(MODE_RECORD, zone_origin(9), 'h10);     // table full
    queue_request(MODE_RECORD, z5 + 'h1800, 'h100);       // full takes priority over overlap
    queue_request(MODE_REPORT, 0, 0);
    queue_request(MODE_SCAN_BEGIN, 0, 0);
    queue_request(MODE_RELEASE, z5 + 'h1FFF, 0);
    queue_request(MODE_RELEASE, z5 + 'h0800, 0);
    queue_request(MODE_RELEASE, z5 + 'h200F, 0);
    for (int i = 0; i < fill; i++)
      queue_request(MODE_RELEASE, zone_origin(7) + i * 'h10000 + 'hFF, 0);
    queue_request(MODE_REPORT, 0, 0);
    queue_random(15);

    wait_idle();
    repeat (16) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
rtl/core/art_pkg.sv
rtl/core/art_datapath.sv
rtl/core/art_ctrl.sv
rtl/core/allocation_reference_tracker_top.sv
verif/allocation_reference_tracker_top_test.sv
